### design/mtli_pkg.sv
// Package for the table interpolator: sizes, controller states and the
// command/status structs that join controller and datapath. No dependencies.
`default_nettype none
package mtli_pkg;

    localparam int MAX_ROWS  = 1024;
    localparam int ROW_W     = $clog2(MAX_ROWS);
    localparam int CNT_W     = ROW_W + 1;
    localparam int FRAC_BITS = 16;
    localparam int VAL_W     = 32;
    localparam int PROD_W    = 2 * VAL_W;
    localparam int DIV_W     = $clog2(PROD_W);

    // Input transaction commands
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FIRST,
        ST_SCAN,
        ST_MUL,
        ST_DIV,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic accept;
        logic first;
        logic step;
        logic latch;
        logic mul;
        logic div;
        logic finish;
    } ctrl_t;

    typedef struct packed {
        logic found;
        logic div_done;
        logic out_free;
    } stat_t;

    // Pick one 32-bit column out of a table row
    function automatic logic signed [VAL_W-1:0] col_sel(
        input logic [4*VAL_W-1:0] row,
        input logic [1:0]         idx
    );
        logic signed [VAL_W-1:0] v;
        case (idx)
            2'd0:    v = row[VAL_W-1:0];
            2'd1:    v = row[2*VAL_W-1:VAL_W];
            2'd2:    v = row[3*VAL_W-1:2*VAL_W];
            default: v = row[4*VAL_W-1:3*VAL_W];
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

### design/mtli_ctrl.sv
// Controller state machine for the table interpolator.
// Depends on mtli_pkg for state, command and status types.
`default_nettype none
module mtli_ctrl (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_valid,
    input  wire logic            s_cmd,
    output logic                 s_ready,
    input  mtli_pkg::stat_t      stat,
    output mtli_pkg::ctrl_t      ctrl
);

    mtli_pkg::state_t state_reg, state_next;

    // Hold state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= mtli_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Sequence one transaction at a time
    always_comb begin
        state_next = state_reg;
        ctrl       = '0;
        s_ready    = 1'b0;
        case (state_reg)
            mtli_pkg::ST_IDLE: begin
                s_ready     = aresetn;
                ctrl.accept = s_valid && aresetn;
                if (aresetn && s_valid && (s_cmd == mtli_pkg::CMD_QUERY)) begin
                    state_next = mtli_pkg::ST_FIRST;
                end
            end
            mtli_pkg::ST_FIRST: begin
                ctrl.first = 1'b1;
                state_next = mtli_pkg::ST_SCAN;
            end
            mtli_pkg::ST_SCAN: begin
                if (stat.found) begin
                    ctrl.latch = 1'b1;
                    state_next = mtli_pkg::ST_MUL;
                end else begin
                    ctrl.step = 1'b1;
                end
            end
            mtli_pkg::ST_MUL: begin
                ctrl.mul   = 1'b1;
                state_next = mtli_pkg::ST_DIV;
            end
            mtli_pkg::ST_DIV: begin
                ctrl.div = 1'b1;
                if (stat.div_done) begin
                    state_next = mtli_pkg::ST_FIN;
                end
            end
            mtli_pkg::ST_FIN: begin
                if (stat.out_free) begin
                    ctrl.finish = 1'b1;
                    state_next  = mtli_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = mtli_pkg::ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

### design/mtli_dp.sv
// Datapath for the table interpolator: table memory, segment scan,
// multiplier, restoring divider and saturating output register. Uses mtli_pkg.
`default_nettype none
module mtli_dp (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  mtli_pkg::ctrl_t                           ctrl,
    output mtli_pkg::stat_t                           stat,
    input  wire logic                                 cfg_wr_en,
    input  wire logic [mtli_pkg::CNT_W-1:0]           cfg_wr_data,
    input  wire logic                                 s_cmd,
    input  wire logic [mtli_pkg::ROW_W-1:0]           s_row_index,
    input  wire logic signed [mtli_pkg::VAL_W-1:0]    s_col0_value,
    input  wire logic signed [mtli_pkg::VAL_W-1:0]    s_col1_value,
    input  wire logic signed [mtli_pkg::VAL_W-1:0]    s_col2_value,
    input  wire logic signed [mtli_pkg::VAL_W-1:0]    s_col3_value,
    input  wire logic signed [mtli_pkg::VAL_W-1:0]    s_query_value,
    input  wire logic [1:0]                           s_key_column,
    input  wire logic [1:0]                           s_target_column,
    output logic                                      m_valid,
    input  wire logic                                 m_ready,
    output logic signed [mtli_pkg::VAL_W-1:0]         m_interpolated_value,
    output logic [mtli_pkg::ROW_W-1:0]                m_segment_index,
    output logic                                      m_zero_span,
    output logic                                      m_saturated
);

    localparam int VW = mtli_pkg::VAL_W;
    localparam int RW = mtli_pkg::ROW_W;
    localparam int CW = mtli_pkg::CNT_W;
    localparam int PW = mtli_pkg::PROD_W;
    localparam int DW = mtli_pkg::DIV_W;
    localparam int QB = VW + 2;   // quotient at or above 2^QB saturates

    logic [4*VW-1:0] mem [mtli_pkg::MAX_ROWS];
    logic [4*VW-1:0] rdata_reg, prev_reg;
    logic [CW-1:0]   rows_reg;
    logic [RW-1:0]   j_reg, j_next, last_j, seg_reg;
    logic signed [VW-1:0] x_reg, t0_reg;
    logic [1:0]      kc_reg, tc_reg;
    logic [VW-1:0]   mag_dt_reg, mag_dx_reg, mag_sp_reg;
    logic            neg_reg, zero_reg;
    logic [PW-1:0]   quot_reg;
    logic [VW-1:0]   rem_reg;
    logic [DW-1:0]   cnt_reg;
    logic            m_valid_reg;

    // Clamp the row count to 2..MAX_ROWS and find the last row scanned
    always_comb begin
        logic [CW-1:0] n;
        n = rows_reg;
        if (n < CW'(2)) n = CW'(2);
        if (n > CW'(mtli_pkg::MAX_ROWS)) n = CW'(mtli_pkg::MAX_ROWS);
        last_j = RW'(n - CW'(1));
    end

    // Config register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_reg <= CW'(2);
        end else if (cfg_wr_en) begin
            rows_reg <= cfg_wr_data;
        end
    end

    // Advance the scan address
    always_comb begin
        j_next = j_reg;
        if (ctrl.accept)     j_next = '0;
        else if (ctrl.first) j_next = RW'(1);
        else if (ctrl.step)  j_next = j_reg + RW'(1);
    end

    // Table memory: write on a load transaction, read the scan row
    always_ff @(posedge aclk) begin
        if (ctrl.accept && (s_cmd == mtli_pkg::CMD_LOAD)) begin
            mem[s_row_index] <= {s_col3_value, s_col2_value, s_col1_value, s_col0_value};
        end
        rdata_reg <= mem[j_next];
    end

    always_ff @(posedge aclk) begin
        j_reg <= j_next;
        if (ctrl.accept) begin
            x_reg  <= s_query_value;
            kc_reg <= s_key_column;
            tc_reg <= s_target_column;
        end
        if (ctrl.first || ctrl.step) begin
            prev_reg <= rdata_reg;
        end
    end

    // Bracket and direction tests on keys of rows j-1 and j
    logic signed [VW-1:0] ka, kb, ta, tb;
    logic bracket, dir_ok, found;
    always_comb begin
        ka = mtli_pkg::col_sel(prev_reg, kc_reg);
        kb = mtli_pkg::col_sel(rdata_reg, kc_reg);
        ta = mtli_pkg::col_sel(prev_reg, tc_reg);
        tb = mtli_pkg::col_sel(rdata_reg, tc_reg);
        bracket = !(((kb > x_reg) && (ka > x_reg)) || ((kb < x_reg) && (ka < x_reg)));
        dir_ok  = !(((kb > ka) && (ka < x_reg)) || ((kb < ka) && (ka > x_reg)));
        found   = bracket || (j_reg == last_j) || ((j_reg == RW'(1)) && dir_ok);
    end

    // Latch the segment as magnitudes and a result sign
    logic signed [VW:0] span, dt, dx;
    always_comb begin
        span = {kb[VW-1], kb} - {ka[VW-1], ka};
        dt   = {tb[VW-1], tb} - {ta[VW-1], ta};
        dx   = {x_reg[VW-1], x_reg} - {ka[VW-1], ka};
    end

    function automatic logic [VW-1:0] mag33(input logic signed [VW:0] v);
        logic [VW:0] a;
        a = v[VW] ? -v : v;
        return a[VW-1:0];
    endfunction

    always_ff @(posedge aclk) begin
        if (ctrl.latch) begin
            seg_reg    <= j_reg - RW'(1);
            t0_reg     <= ta;
            mag_dt_reg <= mag33(dt);
            mag_dx_reg <= mag33(dx);
            mag_sp_reg <= mag33(span);
            neg_reg    <= (dt[VW] ^ dx[VW] ^ span[VW]) && (dt != '0) && (dx != '0);
            zero_reg   <= (span == '0);
        end
    end

    // Multiply, then divide one quotient bit per cycle
    logic [VW:0] rem_sh;
    logic        qbit;
    always_comb begin
        rem_sh = {rem_reg, quot_reg[PW-1]};
        qbit   = (rem_sh >= {1'b0, mag_sp_reg});
    end

    always_ff @(posedge aclk) begin
        if (ctrl.mul) begin
            quot_reg <= PW'(mag_dt_reg) * PW'(mag_dx_reg);
            rem_reg  <= '0;
            cnt_reg  <= '0;
        end else if (ctrl.div) begin
            quot_reg <= {quot_reg[PW-2:0], qbit};
            rem_reg  <= qbit ? VW'(rem_sh - {1'b0, mag_sp_reg}) : rem_sh[VW-1:0];
            cnt_reg  <= cnt_reg + DW'(1);
        end
    end

    // Apply sign, add start target, saturate; a zero span gives the start target
    localparam logic signed [QB+1:0] SUM_MAX = $signed((QB+2)'({1'b0, {(VW-1){1'b1}}}));
    localparam logic signed [QB+1:0] SUM_MIN = ~SUM_MAX;
    logic signed [QB+1:0]  dval, sum;
    logic signed [VW-1:0]  res;
    logic                  sat;
    always_comb begin
        dval = $signed({2'b00, quot_reg[QB-1:0]});
        if (neg_reg) dval = -dval;
        sum = dval + (QB+2)'(t0_reg);
        res = sum[VW-1:0];
        sat = 1'b0;
        if (|quot_reg[PW-1:QB]) begin
            sat = 1'b1;
            res = neg_reg ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}};
        end else if (sum > SUM_MAX) begin
            sat = 1'b1;
            res = {1'b0, {(VW-1){1'b1}}};
        end else if (sum < SUM_MIN) begin
            sat = 1'b1;
            res = {1'b1, {(VW-1){1'b0}}};
        end
        if (zero_reg) begin
            res = t0_reg;
            sat = 1'b0;
        end
    end

    // Status back to the controller
    assign stat = '{found:    found,
                    div_done: (cnt_reg == {DW{1'b1}}),
                    out_free: (!m_valid_reg || m_ready)};

    // Output register: hold the result until the transaction is taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (ctrl.finish) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.finish) begin
            m_interpolated_value <= res;
            m_segment_index      <= seg_reg;
            m_zero_span          <= zero_reg;
            m_saturated          <= sat;
        end
    end

    assign m_valid = m_valid_reg;

endmodule
`default_nettype wire

### design/monotone_table_linear_interpolator_unit.sv
// Top level of the monotone table linear interpolator.
// Instantiates mtli_ctrl and mtli_dp; types come from mtli_pkg.
//
// A load transaction writes one four-column row and gives no result. A
// query scans key rows from row 0 one row per cycle through the single
// read port of the table memory and stops at the first bracketing
// segment, at the first segment when the query does not lie past the key
// of row 0 in the direction of row 1, or at the last. It then multiplies
// and divides with a restoring divider. Rows never loaded must not be
// reached by a query.
`default_nettype none
module monotone_table_linear_interpolator_unit (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               cfg_wr_en,
    input  wire logic [mtli_pkg::CNT_W-1:0]         cfg_wr_data,
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic                               s_cmd,
    input  wire logic [mtli_pkg::ROW_W-1:0]         s_row_index,
    input  wire logic signed [mtli_pkg::VAL_W-1:0]  s_col0_value,
    input  wire logic signed [mtli_pkg::VAL_W-1:0]  s_col1_value,
    input  wire logic signed [mtli_pkg::VAL_W-1:0]  s_col2_value,
    input  wire logic signed [mtli_pkg::VAL_W-1:0]  s_col3_value,
    input  wire logic signed [mtli_pkg::VAL_W-1:0]  s_query_value,
    input  wire logic [1:0]                         s_key_column,
    input  wire logic [1:0]                         s_target_column,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic signed [mtli_pkg::VAL_W-1:0]       m_interpolated_value,
    output logic [mtli_pkg::ROW_W-1:0]              m_segment_index,
    output logic                                    m_zero_span,
    output logic                                    m_saturated
);

    mtli_pkg::ctrl_t ctrl;
    mtli_pkg::stat_t stat;

    mtli_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_cmd   (s_cmd),
        .s_ready (s_ready),
        .stat    (stat),
        .ctrl    (ctrl)
    );

    mtli_dp u_dp (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .ctrl                 (ctrl),
        .stat                 (stat),
        .cfg_wr_en            (cfg_wr_en),
        .cfg_wr_data          (cfg_wr_data),
        .s_cmd                (s_cmd),
        .s_row_index          (s_row_index),
        .s_col0_value         (s_col0_value),
        .s_col1_value         (s_col1_value),
        .s_col2_value         (s_col2_value),
        .s_col3_value         (s_col3_value),
        .s_query_value        (s_query_value),
        .s_key_column         (s_key_column),
        .s_target_column      (s_target_column),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_interpolated_value (m_interpolated_value),
        .m_segment_index      (m_segment_index),
        .m_zero_span          (m_zero_span),
        .m_saturated          (m_saturated)
    );

endmodule
`default_nettype wire

### test/tb.sv
// Testbench for monotone_table_linear_interpolator_unit: loads tables, runs
// directed and random queries and checks each result against a local predictor
// or a directed expectation. Depends on mtli_pkg and the RTL under design/.
`default_nettype none
module tb;

    localparam int WDOG_LIMIT = 40000;
    localparam int HOLD_LEN   = 3000;
    localparam int BIG_LOAD   = 100;

    typedef struct {
        bit                                 cmd;
        logic [mtli_pkg::ROW_W-1:0]         row;
        logic signed [mtli_pkg::VAL_W-1:0]  c0, c1, c2, c3;
        logic signed [mtli_pkg::VAL_W-1:0]  x;
        logic [1:0]                         kc, tc;
        bit                                 typed;
        logic signed [mtli_pkg::VAL_W-1:0]  e_val;
        logic [mtli_pkg::ROW_W-1:0]         e_seg;
        bit                                 e_zs, e_sat;
    } stim_t;

    typedef struct {
        logic signed [mtli_pkg::VAL_W-1:0] val;
        logic [mtli_pkg::ROW_W-1:0]        seg;
        logic                              zs;
        logic                              sat;
    } interp_t;

    logic aclk, aresetn;
    logic cfg_wr_en;
    logic [mtli_pkg::CNT_W-1:0] cfg_wr_data;
    logic s_valid, s_ready, s_cmd;
    logic [mtli_pkg::ROW_W-1:0] s_row_index;
    logic signed [mtli_pkg::VAL_W-1:0] s_col0_value, s_col1_value;
    logic signed [mtli_pkg::VAL_W-1:0] s_col2_value, s_col3_value;
    logic signed [mtli_pkg::VAL_W-1:0] s_query_value;
    logic [1:0] s_key_column, s_target_column;
    logic m_valid, m_ready;
    logic signed [mtli_pkg::VAL_W-1:0] m_interpolated_value;
    logic [mtli_pkg::ROW_W-1:0] m_segment_index;
    logic m_zero_span, m_saturated;

    monotone_table_linear_interpolator_unit u_top (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_cmd(s_cmd),
        .s_row_index(s_row_index),
        .s_col0_value(s_col0_value), .s_col1_value(s_col1_value),
        .s_col2_value(s_col2_value), .s_col3_value(s_col3_value),
        .s_query_value(s_query_value),
        .s_key_column(s_key_column), .s_target_column(s_target_column),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_interpolated_value(m_interpolated_value),
        .m_segment_index(m_segment_index),
        .m_zero_span(m_zero_span), .m_saturated(m_saturated)
    );

    // Predictor state: table copy, effective row count and rows loaded
    logic signed [mtli_pkg::VAL_W-1:0] tbl_model [mtli_pkg::MAX_ROWS][4];
    int rows_eff;
    int rows_ld;
    interp_t pending_results [$];
    stim_t dir_tab [$];
    int errors;
    int src_idle_pct, snk_idle_pct;
    int hold_left;
    int quiet_cycles;

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    task automatic report(input string msg);
        $display("tb: mismatch: %s", msg);
        errors++;
    endtask

    // Queue one expected result and one directed row
    task automatic expect_result(input interp_t r);
        pending_results = {pending_results, r};
    endtask

    task automatic add_row(input stim_t t);
        dir_tab = {dir_tab, t};
    endtask

    function automatic int sgn(input longint v);
        return (v > 0) - (v < 0);
    endfunction

    function automatic longint unsigned mag(input longint v);
        return v < 0 ? longint'(-v) : v;
    endfunction

    // Compute the expected result of one query from the table copy
    function automatic interp_t interpolate(input logic signed [mtli_pkg::VAL_W-1:0] xq,
                                            input logic [1:0] kc, input logic [1:0] tc);
        interp_t r;
        int i, last;
        longint xv, k0, k1, t0, t1, span, dt, dx, res, a, b;
        longint unsigned q;
        int s;
        last = rows_eff - 2;
        xv = xq;
        k0 = tbl_model[0][kc];
        k1 = tbl_model[1][kc];
        i = 0;
        if (sgn(k1 - k0) * sgn(k0 - xv) < 0) begin
            for (i = 0; i < last; i++) begin
                a = tbl_model[i][kc];
                b = tbl_model[i+1][kc];
                if (sgn(b - xv) * sgn(xv - a) >= 0) break;
            end
        end
        k0 = tbl_model[i][kc];
        k1 = tbl_model[i+1][kc];
        t0 = tbl_model[i][tc];
        t1 = tbl_model[i+1][tc];
        span = k1 - k0;
        r.seg = i[mtli_pkg::ROW_W-1:0];
        if (span == 0) begin
            r.val = t0[mtli_pkg::VAL_W-1:0];
            r.zs = 1'b1;
            r.sat = 1'b0;
            return r;
        end
        dt = t1 - t0;
        dx = xv - k0;
        s = sgn(dt) * sgn(dx) * sgn(span);
        q = (mag(dt) * mag(dx)) / mag(span);
        r.zs = 1'b0;
        r.sat = 1'b0;
        if (q >= (64'd1 << 34)) begin
            res = s < 0 ? -64'sd2147483648 : 64'sd2147483647;
            r.sat = 1'b1;
        end else begin
            res = t0 + (s < 0 ? -longint'(q) : longint'(q));
            if (res > 64'sd2147483647) begin
                res = 64'sd2147483647;
                r.sat = 1'b1;
            end else if (res < -64'sd2147483648) begin
                res = -64'sd2147483648;
                r.sat = 1'b1;
            end
        end
        r.val = res[mtli_pkg::VAL_W-1:0];
        return r;
    endfunction

    function automatic stim_t mk_load(input int row, input logic [31:0] c0, c1, c2, c3);
        stim_t t;
        t = '{default: '0};
        t.cmd = mtli_pkg::CMD_LOAD;
        t.row = row[mtli_pkg::ROW_W-1:0];
        t.c0 = c0; t.c1 = c1; t.c2 = c2; t.c3 = c3;
        t.x = $urandom; t.kc = 2'($urandom); t.tc = 2'($urandom);
        return t;
    endfunction

    function automatic stim_t mk_query(input logic [31:0] xq, input int kc, tc,
                                       input bit typed, input logic [31:0] v,
                                       input int seg, input bit zs, sat);
        stim_t t;
        t = '{default: '0};
        t.cmd = mtli_pkg::CMD_QUERY;
        t.row = mtli_pkg::ROW_W'($urandom);
        t.c0 = $urandom; t.c1 = $urandom; t.c2 = $urandom; t.c3 = $urandom;
        t.x = xq; t.kc = 2'(kc); t.tc = 2'(tc);
        t.typed = typed; t.e_val = v; t.e_seg = mtli_pkg::ROW_W'(seg);
        t.e_zs = zs; t.e_sat = sat;
        return t;
    endfunction

    // Offer one transaction; valid is left high so back-to-back items need no drop
    task automatic send(input stim_t t);
        interp_t r;
        if ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < src_idle_pct);
        end
        s_valid <= 1'b1;
        s_cmd <= t.cmd;
        s_row_index <= t.row;
        s_col0_value <= t.c0; s_col1_value <= t.c1;
        s_col2_value <= t.c2; s_col3_value <= t.c3;
        s_query_value <= t.x;
        s_key_column <= t.kc;
        s_target_column <= t.tc;
        do @(posedge aclk); while (!s_ready);
        if (t.cmd == mtli_pkg::CMD_LOAD) begin
            tbl_model[t.row][0] = t.c0; tbl_model[t.row][1] = t.c1;
            tbl_model[t.row][2] = t.c2; tbl_model[t.row][3] = t.c3;
        end else if (t.typed) begin
            r.val = t.e_val; r.seg = t.e_seg; r.zs = t.e_zs; r.sat = t.e_sat;
            expect_result(r);
        end else begin
            expect_result(interpolate(t.x, t.kc, t.tc));
        end
    endtask

    // Drop valid, wait for all results, then let a trailing load settle
    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_results.size() != 0);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_rows(input int value);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value[mtli_pkg::CNT_W-1:0];
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        rows_eff = value[mtli_pkg::CNT_W-1:0];
        if (rows_eff < 2) rows_eff = 2;
        if (rows_eff > mtli_pkg::MAX_ROWS) rows_eff = mtli_pkg::MAX_ROWS;
    endtask

    // Load rows 0..n-1: each column rising, falling or random
    task automatic load_table(input int n);
        int mode [4];
        longint v [4];
        longint stepmax;
        logic [31:0] c [4];
        stepmax = 64'd4000000000 / n;
        for (int k = 0; k < 4; k++) begin
            mode[k] = $urandom_range(2);
            v[k] = mode[k] == 1 ? 64'sd2147483647 - $urandom_range(1 << 20)
                                : -64'sd2147483648 + $urandom_range(1 << 20);
        end
        for (int r = 0; r < n; r++) begin
            for (int k = 0; k < 4; k++) begin
                if (mode[k] == 2) begin
                    c[k] = $urandom;
                end else begin
                    if (r > 0 && $urandom_range(5) != 0)
                        v[k] += (mode[k] == 0 ? 1 : -1) * longint'($urandom_range(stepmax));
                    if (v[k] > 64'sd2147483647) v[k] = 64'sd2147483647;
                    if (v[k] < -64'sd2147483648) v[k] = -64'sd2147483648;
                    c[k] = v[k][31:0];
                end
            end
            send(mk_load(r, c[0], c[1], c[2], c[3]));
        end
    endtask

    // Random query: mostly inside or on the table's keys, some anywhere;
    // with only part of the table loaded, stay inside a loaded segment
    function automatic stim_t rand_query();
        int kc, j, pick;
        longint a, b;
        logic [31:0] xq;
        kc = $urandom_range(3);
        j = $urandom_range(rows_ld - 2);
        a = tbl_model[j][kc];
        b = tbl_model[j+1][kc];
        pick = $urandom_range(7);
        if (rows_ld < rows_eff && pick < 2) pick = 2;
        case (pick)
            0, 1:    xq = $urandom;
            2:       xq = a[31:0];
            default: begin
                a = a + ((b - a) * longint'($urandom_range(1000))) / 1000;
                xq = a[31:0];
            end
        endcase
        return mk_query(xq, kc, $urandom_range(3), 0, 0, 0, 0, 0);
    endfunction

    // Receiver: random stalls, or a long hold-off when asked
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            m_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else begin
            m_ready <= $urandom_range(99) >= snk_idle_pct;
        end
    end

    // Compare each result transaction with the oldest expectation
    always @(posedge aclk) begin
        interp_t e;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                report("result with none expected");
            end else begin
                e = pending_results.pop_front();
                if (m_interpolated_value !== e.val)
                    report($sformatf("value %h, want %h", m_interpolated_value, e.val));
                if (m_segment_index !== e.seg)
                    report($sformatf("segment %0d, want %0d", m_segment_index, e.seg));
                if (m_zero_span !== e.zs)
                    report($sformatf("zero_span %b, want %b", m_zero_span, e.zs));
                if (m_saturated !== e.sat)
                    report($sformatf("saturated %b, want %b", m_saturated, e.sat));
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WDOG_LIMIT) begin
            $display("tb: done, errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int cfgs [12];
        int nq;
        cfgs = '{0, 3, 2047, 1, 5, 8, 16, 2, 12, 4, 7, 6};
        errors = 0;
        hold_left = 0;
        quiet_cycles = 0;
        src_idle_pct = 13;
        snk_idle_pct = 68;
        rows_eff = 2;
        rows_ld = 2;
        aresetn <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_wr_data <= '0;
        s_valid <= 1'b0;
        s_cmd <= mtli_pkg::CMD_LOAD;
        s_row_index <= '0;
        s_col0_value <= '0; s_col1_value <= '0; s_col2_value <= '0; s_col3_value <= '0;
        s_query_value <= '0;
        s_key_column <= '0;
        s_target_column <= '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part with the two rows in use after reset
        add_row(mk_load(0, 32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000));
        add_row(mk_load(1, 32'h0001_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0001_0000));
        // flat target column
        add_row(mk_query(32'h0000_8000, 0, 3, 1, 32'h0001_0000, 0, 0, 0));
        // zero key span gives the start target
        add_row(mk_query(32'h0000_8000, 3, 0, 1, 32'h0, 0, 1, 0));
        // far before the first key, clipped high
        add_row(mk_query(32'h8000_0000, 0, 1, 1, 32'h7FFF_FFFF, 0, 0, 1));
        // far past the last key, clipped high
        add_row(mk_query(32'h7FFF_FFFF, 0, 2, 1, 32'h7FFF_FFFF, 0, 0, 1));
        // clipped low
        add_row(mk_query(32'h7FFF_FFFF, 0, 1, 1, 32'h8000_0000, 0, 0, 1));
        add_row(mk_query(32'h0, 1, 0, 0, 0, 0, 0, 0));
        add_row(mk_query(32'hFFFF_FFFF, 1, 3, 0, 0, 0, 0, 0));
        add_row(mk_query(32'h0000_4000, 0, 0, 0, 0, 0, 0, 0));
        add_row(mk_query(32'h0001_0000, 2, 3, 0, 0, 0, 0, 0));
        add_row(mk_query(32'h1234_5678, 2, 1, 0, 0, 0, 0, 0));
        foreach (dir_tab[k]) send(dir_tab[k]);
        drain();

        // Random phases over several row counts, extremes included
        foreach (cfgs[p]) begin
            if (p < 4) begin
                src_idle_pct = 13; snk_idle_pct = 68;
            end else if (p < 8) begin
                src_idle_pct = 68; snk_idle_pct = 13;
            end else begin
                src_idle_pct = 0; snk_idle_pct = 0;
            end
            write_rows(cfgs[p]);
            rows_ld = rows_eff == mtli_pkg::MAX_ROWS ? BIG_LOAD : rows_eff;
            load_table(rows_ld);
            if (p == 1) hold_left = HOLD_LEN;
            nq = 30;
            for (int k = 0; k < nq; k++) begin
                if ($urandom_range(9) == 0)
                    send(mk_load($urandom_range(rows_ld - 1), $urandom, $urandom,
                                 $urandom, $urandom));
                else
                    send(rand_query());
            end
            drain();
        end

        repeat (20) @(posedge aclk);
        if (errors == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end
endmodule
`default_nettype wire

### filelist.f
design/mtli_pkg.sv
design/mtli_ctrl.sv
design/mtli_dp.sv
design/monotone_table_linear_interpolator_unit.sv
test/tb.sv
